// ----- rtl/ajr_pkg.sv -----
// shared types and constants for the audio jitter ring player
`timescale 1ns / 1ps

package ajr_pkg;

   // operation codes carried in req_tuser
   localparam logic [2:0] OP_START = 3'd0;
   localparam logic [2:0] OP_WRITE = 3'd1;
   localparam logic [2:0] OP_PULL  = 3'd2;
   localparam logic [2:0] OP_END   = 3'd3;
   localparam logic [2:0] OP_TICK  = 3'd4;
   localparam logic [2:0] OP_STOP  = 3'd5;
   localparam logic [2:0] OP_ERROR = 3'd6;

   // player modes
   localparam logic [2:0] MODE_IDLE  = 3'd0;
   localparam logic [2:0] MODE_BUF   = 3'd1;
   localparam logic [2:0] MODE_PLAY  = 3'd2;
   localparam logic [2:0] MODE_DRAIN = 3'd3;
   localparam logic [2:0] MODE_DONE  = 3'd4;
   localparam logic [2:0] MODE_ERR   = 3'd5;

   // register indexes
   localparam logic [1:0] CSR_EXPECTED = 2'd0;
   localparam logic [1:0] CSR_PREBUF   = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT  = 2'd2;

   localparam int SAMPLE_BITS = 16;
   localparam int FILL_BITS   = 12;
   localparam int CNT_BITS    = 16;
   localparam int BYTE_BITS   = 8;

   localparam logic [31:0]          EXPECTED_RESET = 32'd0;
   localparam logic [FILL_BITS-1:0] PREBUF_RESET   = 12'd2048;
   localparam logic [CNT_BITS-1:0]  TIMEOUT_RESET  = 16'd5000;
   localparam logic [CNT_BITS-1:0]  CNT_MAX        = 16'hFFFF;

   // ring memory port controls
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

   // per-transfer status, everything but the sample bytes
   typedef struct packed {
      logic                 sample_valid;
      logic                 byte_accepted;
      logic [2:0]           player_state;
      logic [FILL_BITS-1:0] fill_level;
      logic [CNT_BITS-1:0]  underrun_total;
   } result_type;

endpackage

// ----- rtl/ajr_ring_mem.sv -----
// byte ring storage: one write port, two registered read ports
`timescale 1ns / 1ps

module ajr_ring_mem import ajr_pkg::*; #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic                 clock,
   input  mem_ctl_type          ctl,
   input  logic [AW-1:0]        wr_addr,
   input  logic [BYTE_BITS-1:0] wr_data,
   input  logic [AW-1:0]        rd_addr0,
   input  logic [AW-1:0]        rd_addr1,
   output logic [BYTE_BITS-1:0] rd_data0,
   output logic [BYTE_BITS-1:0] rd_data1
);

   logic [BYTE_BITS-1:0] mem [DEPTH];
   logic [BYTE_BITS-1:0] rd0_ff;
   logic [BYTE_BITS-1:0] rd1_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd0_ff <= mem[rd_addr0];
         rd1_ff <= mem[rd_addr1];
      end
   end

   assign rd_data0 = rd0_ff;
   assign rd_data1 = rd1_ff;

endmodule

// ----- rtl/ajr_ctrl.sv -----
// pointer, counter and mode update for one accepted transfer per cycle
`timescale 1ns / 1ps

module ajr_ctrl import ajr_pkg::*; #(
   parameter int RING_BYTES = 4096,
   parameter int AW         = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_wdata,
   input  logic                 accept,
   input  logic [2:0]           operation,
   input  logic                 half_end,
   output mem_ctl_type          mem_ctl,
   output logic [AW-1:0]        wr_addr,
   output logic [AW-1:0]        rd_addr0,
   output logic [AW-1:0]        rd_addr1,
   output result_type           result
);

   localparam int FW = (AW > FILL_BITS) ? AW : FILL_BITS;
   localparam logic [AW-1:0] LAST_POS = AW'(RING_BYTES - 1);

   function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
      next_pos = (p == LAST_POS) ? '0 : p + AW'(1);
   endfunction

   function automatic logic [AW-1:0] fill_of(input logic [AW-1:0] w, input logic [AW-1:0] r);
      logic [AW:0] wrap;
      wrap = {1'b0, w} + (AW + 1)'(RING_BYTES) - {1'b0, r};
      fill_of = (w >= r) ? (w - r) : wrap[AW-1:0];
   endfunction

   // configuration
   logic [31:0]           expected_ff;
   logic [FILL_BITS-1:0]  prebuf_ff;
   logic [CNT_BITS-1:0]   timeout_ff;

   // player state
   logic [AW-1:0]         wp_ff, wp_in;
   logic [AW-1:0]         rp_ff, rp_in;
   logic [31:0]           bin_ff, bin_in;
   logic [31:0]           bout_ff, bout_in;
   logic                  end_ff, end_in;
   logic                  fin_ff, fin_in;
   logic                  err_ff, err_in;
   logic [2:0]            mode_ff, mode_in;
   logic [CNT_BITS-1:0]   short_ff, short_in;
   logic [CNT_BITS-1:0]   idle_ff, idle_in;
   logic                  hgot_ff, hgot_in;
   logic                  hshort_ff, hshort_in;

   logic [AW-1:0]         fill_cur;
   logic [AW-1:0]         fill_new;
   logic [FW-1:0]         fill_new_ext;
   logic                  active_cur;
   logic                  run;
   logic                  accepted;
   logic                  svalid;
   logic                  wr_en;
   logic                  rd_en;

   assign fill_cur   = fill_of(wp_ff, rp_ff);
   assign active_cur = mode_ff inside {MODE_BUF, MODE_PLAY, MODE_DRAIN};

   always_comb begin
      wp_in     = wp_ff;
      rp_in     = rp_ff;
      bin_in    = bin_ff;
      bout_in   = bout_ff;
      end_in    = end_ff;
      fin_in    = fin_ff;
      err_in    = err_ff;
      mode_in   = mode_ff;
      short_in  = short_ff;
      idle_in   = idle_ff;
      hgot_in   = hgot_ff;
      hshort_in = hshort_ff;
      run       = 1'b0;
      accepted  = 1'b0;
      svalid    = 1'b0;
      wr_en     = 1'b0;
      rd_en     = 1'b0;

      if (accept) begin
         case (operation)
            OP_START: begin
               wp_in     = '0;
               rp_in     = '0;
               bin_in    = '0;
               bout_in   = '0;
               end_in    = 1'b0;
               fin_in    = 1'b0;
               err_in    = 1'b0;
               short_in  = '0;
               idle_in   = '0;
               hgot_in   = 1'b0;
               hshort_in = 1'b0;
               mode_in   = MODE_BUF;
            end
            OP_WRITE: begin
               if (active_cur && (fill_cur < LAST_POS) && (bin_ff < expected_ff)) begin
                  wr_en    = 1'b1;
                  wp_in    = next_pos(wp_ff);
                  bin_in   = bin_ff + 32'd1;
                  idle_in  = '0;
                  accepted = 1'b1;
               end
               run = 1'b1;
            end
            OP_PULL: begin
               if (mode_ff inside {MODE_PLAY, MODE_DRAIN}) begin
                  if (fill_cur >= AW'(2)) begin
                     rd_en   = 1'b1;
                     svalid  = 1'b1;
                     rp_in   = next_pos(next_pos(rp_ff));
                     bout_in = bout_ff + 32'd2;
                     hgot_in = 1'b1;
                  end else begin
                     hshort_in = 1'b1;
                  end
                  if (half_end) begin
                     if (hshort_in && !end_ff && (short_ff != CNT_MAX)) begin
                        short_in = short_ff + CNT_BITS'(1);
                     end
                     if (end_ff && (bout_in >= expected_ff) && !hgot_in) begin
                        fin_in = 1'b1;
                     end
                     hgot_in   = 1'b0;
                     hshort_in = 1'b0;
                  end
                  run = 1'b1;
               end
            end
            OP_END: begin
               end_in = 1'b1;
               if (mode_ff == MODE_PLAY) begin
                  mode_in = MODE_DRAIN;
               end
               run = 1'b1;
            end
            OP_TICK: begin
               if (active_cur) begin
                  if (idle_ff != CNT_MAX) begin
                     idle_in = idle_ff + CNT_BITS'(1);
                  end
                  if (!end_ff && (bin_ff < expected_ff) && (idle_in > timeout_ff)) begin
                     err_in = 1'b1;
                     fin_in = 1'b1;
                  end
                  run = 1'b1;
               end
            end
            OP_STOP: begin
               mode_in = MODE_IDLE;
               fin_in  = 1'b0;
               err_in  = 1'b0;
            end
            OP_ERROR: begin
               err_in  = 1'b1;
               fin_in  = 1'b1;
               mode_in = MODE_ERR;
            end
            default: begin
            end
         endcase
      end

      fill_new     = fill_of(wp_in, rp_in);
      fill_new_ext = FW'(fill_new);

      // end-of-data, prebuffer and finish checks
      if (run && (mode_in inside {MODE_BUF, MODE_PLAY, MODE_DRAIN})) begin
         if (!end_in && (bin_in >= expected_ff)) begin
            end_in = 1'b1;
            if (mode_in == MODE_PLAY) begin
               mode_in = MODE_DRAIN;
            end
         end
         if (mode_in == MODE_BUF) begin
            if (end_in || (fill_new_ext >= FW'(prebuf_ff))) begin
               if (fill_new != '0) begin
                  mode_in = MODE_PLAY;
               end else if (end_in) begin
                  mode_in = MODE_DONE;
                  fin_in  = 1'b1;
               end
            end
         end
         if (fin_in) begin
            mode_in = err_in ? MODE_ERR : MODE_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= EXPECTED_RESET;
         prebuf_ff   <= PREBUF_RESET;
         timeout_ff  <= TIMEOUT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_EXPECTED: expected_ff <= csr_wdata;
            CSR_PREBUF:   prebuf_ff   <= csr_wdata[FILL_BITS-1:0];
            CSR_TIMEOUT:  timeout_ff  <= csr_wdata[CNT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff     <= '0;
         rp_ff     <= '0;
         bin_ff    <= '0;
         bout_ff   <= '0;
         end_ff    <= 1'b0;
         fin_ff    <= 1'b0;
         err_ff    <= 1'b0;
         mode_ff   <= MODE_IDLE;
         short_ff  <= '0;
         idle_ff   <= '0;
         hgot_ff   <= 1'b0;
         hshort_ff <= 1'b0;
      end else begin
         wp_ff     <= wp_in;
         rp_ff     <= rp_in;
         bin_ff    <= bin_in;
         bout_ff   <= bout_in;
         end_ff    <= end_in;
         fin_ff    <= fin_in;
         err_ff    <= err_in;
         mode_ff   <= mode_in;
         short_ff  <= short_in;
         idle_ff   <= idle_in;
         hgot_ff   <= hgot_in;
         hshort_ff <= hshort_in;
      end
   end

   assign mem_ctl.wr_en = wr_en;
   assign mem_ctl.rd_en = rd_en;
   assign wr_addr       = wp_ff;
   assign rd_addr0      = rp_ff;
   assign rd_addr1      = next_pos(rp_ff);

   assign result.sample_valid   = svalid;
   assign result.byte_accepted  = accepted;
   assign result.player_state   = mode_in;
   assign result.fill_level     = fill_new_ext[FILL_BITS-1:0];
   assign result.underrun_total = short_in;

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (wp_ff <= LAST_POS) && (rp_ff <= LAST_POS))
      else $error("ring pointer out of range");

   a_rd_mode: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (mode_ff == MODE_PLAY || mode_ff == MODE_DRAIN) && (fill_cur >= AW'(2)))
      else $error("ring read outside playback");

   a_fill_grow: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (fill_cur == $past(fill_cur) + AW'(1)))
      else $error("stored byte did not raise the fill");

   a_wr_room: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (fill_cur < LAST_POS) && !rd_en)
      else $error("byte stored into a full ring");

endmodule

// ----- rtl/audio_jitter_ring_player.sv -----
// top level of the audio jitter ring player
`timescale 1ns / 1ps

// channel  dir  handshake             payload
// req      in   req_tvalid/tready     tuser operation, tdata data_byte, tlast half_end
// rsp      out  rsp_tvalid/tready     tuser sample_valid, tdata sample and status
// csr      in   csr_we                csr_index, csr_wdata (no read-back)
//
// one transfer per cycle while req_tready is high; its result is registered for the next cycle
// pointer and counter update finish in the accept cycle; the ring read lands the cycle after
// a pull reads two bytes at once through two read ports of the ring memory
// req_tready drops only while a result waits and rsp_tready is low
// synchronous active-high reset clears pointers, counters and mode; ring contents are kept

module audio_jitter_ring_player import ajr_pkg::*; #(
   parameter int RING_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [2:0]  req_tuser,   // [2:0] operation
   input  logic        req_tlast,   // half_end
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [15:0] sample, [16] byte_accepted,
                                    // [19:17] player_state, [31:20] fill_level,
                                    // [47:32] underrun_total
   output logic        rsp_tuser,   // sample_valid
   // configuration
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int AW = $clog2(RING_BYTES);

   logic                 accept;
   mem_ctl_type          mem_ctl;
   logic [AW-1:0]        wr_addr;
   logic [AW-1:0]        rd_addr0;
   logic [AW-1:0]        rd_addr1;
   logic [BYTE_BITS-1:0] rd_lo;
   logic [BYTE_BITS-1:0] rd_hi;
   result_type           result;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           rsp_res_ff;
   logic [SAMPLE_BITS-1:0] sample;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   ajr_ctrl #(
      .RING_BYTES (RING_BYTES),
      .AW         (AW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .operation (req_tuser),
      .half_end  (req_tlast),
      .mem_ctl   (mem_ctl),
      .wr_addr   (wr_addr),
      .rd_addr0  (rd_addr0),
      .rd_addr1  (rd_addr1),
      .result    (result)
   );

   // previous-cycle writes are already in the array when a pull reads, so no bypass
   ajr_ring_mem #(
      .DEPTH (RING_BYTES),
      .AW    (AW)
   ) u_ring (
      .clock    (clock),
      .ctl      (mem_ctl),
      .wr_addr  (wr_addr),
      .wr_data  (req_tdata),
      .rd_addr0 (rd_addr0),
      .rd_addr1 (rd_addr1),
      .rd_data0 (rd_lo),
      .rd_data1 (rd_hi)
   );

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // status loads with the transfer; ring read data holds until the next pull
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_res_ff <= result;
      end
   end

   // little-endian join, silence when nothing was read
   assign sample = rsp_res_ff.sample_valid ? {rd_hi, rd_lo} : '0;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_res_ff.sample_valid;
   assign rsp_tdata  = {rsp_res_ff.underrun_total,
                        rsp_res_ff.fill_level,
                        rsp_res_ff.player_state,
                        rsp_res_ff.byte_accepted,
                        sample};

   a_sample_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_res_ff.sample_valid) |->
         (rsp_res_ff.player_state == MODE_PLAY || rsp_res_ff.player_state == MODE_DRAIN ||
          rsp_res_ff.player_state == MODE_DONE || rsp_res_ff.player_state == MODE_ERR))
      else $error("sample delivered outside playback");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_res_ff.sample_valid && rsp_res_ff.byte_accepted))
      else $error("pull and store in one result");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted transfer produced no result");

endmodule

// ----- dv/tb_audio_jitter_ring_player.sv -----
// self-checking testbench for the audio jitter ring player: directed and random stream traffic
`timescale 1ns / 1ps

module tb_audio_jitter_ring_player;
   import ajr_pkg::*;

   localparam int RING_SIZE     = 2 ** FILL_BITS;
   localparam int RANDOM_ITEMS  = 850;
   localparam int LONG_HOLD     = 80;
   localparam int FILL_WRITES   = 150;
   localparam int FILL_ROUNDS   = 40;
   localparam int STARVE_ROUNDS = 30;
   localparam int CYCLE_LIMIT   = 200_000;

   // operation code the block treats as a no-op
   localparam logic [2:0] OP_UNUSED = 3'd7;

   // one expected result transfer, split into the fields of rsp_tdata / rsp_tuser
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   sample_valid;
      logic                   byte_accepted;
      logic [2:0]             player_state;
      logic [FILL_BITS-1:0]   fill_level;
      logic [CNT_BITS-1:0]    underrun_total;
   } player_status_type;

   // mirror of the player: ring, pointers, counters, mode and the three registers
   class player_scoreboard;
      localparam logic [FILL_BITS-1:0] RING_LAST = {FILL_BITS{1'b1}};

      logic [31:0]          expected_bytes;
      logic [FILL_BITS-1:0] prebuffer;
      logic [CNT_BITS-1:0]  rx_timeout;

      logic [7:0]           ring [RING_SIZE];
      logic [FILL_BITS-1:0] wpos, rpos;
      logic [31:0]          n_in, n_out;
      logic                 end_seen, finish_set, error_set, half_got, half_short;
      logic [2:0]           mode;
      logic [CNT_BITS-1:0]  underruns, quiet_ticks;

      player_status_type    status_due [$];
      int                   errors, transfers_in, statuses_seen;
      logic [FILL_BITS-1:0] peak_fill;
      logic [CNT_BITS-1:0]  peak_underruns;
      logic [5:0]           modes_reached;

      function new();
         expected_bytes = EXPECTED_RESET;
         prebuffer      = PREBUF_RESET;
         rx_timeout     = TIMEOUT_RESET;
         foreach (ring[i]) ring[i] = 8'h00;
         wpos = '0; rpos = '0; n_in = '0; n_out = '0;
         end_seen = 1'b0; finish_set = 1'b0; error_set = 1'b0;
         half_got = 1'b0; half_short = 1'b0;
         mode = MODE_IDLE; underruns = '0; quiet_ticks = '0;
         errors = 0; transfers_in = 0; statuses_seen = 0;
         peak_fill = '0; peak_underruns = '0; modes_reached = 6'b000001;
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] value);
         case (idx)
            CSR_EXPECTED: expected_bytes = value;
            CSR_PREBUF:   prebuffer = value[FILL_BITS-1:0];
            CSR_TIMEOUT:  rx_timeout = value[CNT_BITS-1:0];
            default: ;
         endcase
      endfunction

      function logic [FILL_BITS-1:0] fill();
         return wpos - rpos;   // ring size is a power of two
      endfunction

      function logic active();
         return mode == MODE_BUF || mode == MODE_PLAY || mode == MODE_DRAIN;
      endfunction

      // end-of-data, playback start and finish decisions after an active operation
      function void settle();
         logic [FILL_BITS-1:0] f;
         if (!active()) return;
         if (!end_seen && n_in >= expected_bytes) begin
            end_seen = 1'b1;
            if (mode == MODE_PLAY) mode = MODE_DRAIN;
         end
         if (mode == MODE_BUF) begin
            f = fill();
            if (end_seen || f >= prebuffer) begin
               if (f != '0) begin
                  mode = MODE_PLAY;
               end else if (end_seen) begin
                  mode = MODE_DONE;
                  finish_set = 1'b1;
               end
            end
         end
         if (finish_set) mode = error_set ? MODE_ERR : MODE_DONE;
      endfunction

      // called on every accepted request transfer: updates the mirror, queues the status
      function void predict_status(logic [2:0] op, logic [7:0] b, logic hend);
         player_status_type st;
         logic [7:0]        lo, hi;
         st = '0;
         transfers_in++;
         case (op)
            OP_START: begin
               wpos = '0; rpos = '0; n_in = '0; n_out = '0;
               end_seen = 1'b0; finish_set = 1'b0; error_set = 1'b0;
               underruns = '0; quiet_ticks = '0;
               half_got = 1'b0; half_short = 1'b0;
               mode = MODE_BUF;
            end
            OP_WRITE: begin
               if (active() && fill() < RING_LAST && n_in < expected_bytes) begin
                  ring[wpos] = b;
                  wpos = wpos + FILL_BITS'(1);
                  n_in = n_in + 32'd1;
                  quiet_ticks = '0;
                  st.byte_accepted = 1'b1;
               end
               settle();
            end
            OP_PULL: begin
               if (mode == MODE_PLAY || mode == MODE_DRAIN) begin
                  if (fill() >= 2) begin
                     lo = ring[rpos];
                     rpos = rpos + FILL_BITS'(1);
                     hi = ring[rpos];
                     rpos = rpos + FILL_BITS'(1);
                     st.sample = {hi, lo};
                     st.sample_valid = 1'b1;
                     n_out = n_out + 32'd2;
                     half_got = 1'b1;
                  end else begin
                     half_short = 1'b1;
                  end
                  if (hend) begin
                     if (half_short && !end_seen && underruns != CNT_MAX)
                        underruns = underruns + CNT_BITS'(1);
                     if (end_seen && n_out >= expected_bytes && !half_got)
                        finish_set = 1'b1;
                     half_got = 1'b0;
                     half_short = 1'b0;
                  end
                  settle();
               end
            end
            OP_END: begin
               end_seen = 1'b1;
               if (mode == MODE_PLAY) mode = MODE_DRAIN;
               settle();
            end
            OP_TICK: begin
               if (active()) begin
                  if (quiet_ticks != CNT_MAX) quiet_ticks = quiet_ticks + CNT_BITS'(1);
                  if (!end_seen && n_in < expected_bytes && quiet_ticks > rx_timeout) begin
                     error_set = 1'b1;
                     finish_set = 1'b1;
                  end
                  settle();
               end
            end
            OP_STOP: begin
               mode = MODE_IDLE;
               finish_set = 1'b0;
               error_set = 1'b0;
            end
            OP_ERROR: begin
               error_set = 1'b1;
               finish_set = 1'b1;
               mode = MODE_ERR;
            end
            default: ;
         endcase
         st.player_state   = mode;
         st.fill_level     = fill();
         st.underrun_total = underruns;
         if (st.fill_level > peak_fill) peak_fill = st.fill_level;
         if (underruns > peak_underruns) peak_underruns = underruns;
         modes_reached[mode] = 1'b1;
         status_due.push_back(st);
      endfunction

      // called on every accepted result transfer
      function void check_status(logic [47:0] d, logic valid_bit);
         player_status_type want;
         statuses_seen++;
         if (status_due.size() == 0) begin
            $error("result transfer with nothing outstanding, tdata %0h", d);
            errors++;
            return;
         end
         want = status_due.pop_front();
         if (d[15:0] != want.sample) begin
            $error("sample: expected %0h got %0h", want.sample, d[15:0]);
            errors++;
         end
         if (valid_bit != want.sample_valid) begin
            $error("sample_valid: expected %0h got %0h", want.sample_valid, valid_bit);
            errors++;
         end
         if (d[16] != want.byte_accepted) begin
            $error("byte_accepted: expected %0h got %0h", want.byte_accepted, d[16]);
            errors++;
         end
         if (d[19:17] != want.player_state) begin
            $error("player_state: expected %0h got %0h", want.player_state, d[19:17]);
            errors++;
         end
         if (d[31:20] != want.fill_level) begin
            $error("fill_level: expected %0h got %0h", want.fill_level, d[31:20]);
            errors++;
         end
         if (d[47:32] != want.underrun_total) begin
            $error("underrun_total: expected %0h got %0h", want.underrun_total, d[47:32]);
            errors++;
         end
      endfunction

      function int pending();
         return status_due.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid, req_tready;
   logic [7:0]  req_tdata;
   logic [2:0]  req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid, rsp_tready;
   logic [47:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   player_scoreboard sb;

   bit fast_mode    = 1'b0;   // sender offers back to back, no gaps between bursts
   bit hold_request = 1'b0;   // asks the receiver for one long hold-off
   int burst_left   = 0;
   int config_phases = 0;
   int cycle_count;

   audio_jitter_ring_player #(.RING_BYTES(RING_SIZE)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // offer one request and hold it until the transfer happens; gaps fall between bursts
   task automatic push_item(input logic [2:0] op, input logic [7:0] b, input logic hend);
      if (!fast_mode && burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 16);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= b;
      req_tlast  <= hend;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.predict_status(op, b, hend);
      if (burst_left > 0) burst_left--;
   endtask

   // stop offering and wait for every outstanding result, plus the output latency
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_reg(idx, value);
   endtask

   task automatic program_regs(input logic [31:0] exp_bytes, input logic [11:0] prebuf,
                               input logic [15:0] tmo);
      write_reg(CSR_EXPECTED, exp_bytes);
      write_reg(CSR_PREBUF, {20'd0, prebuf});
      write_reg(CSR_TIMEOUT, {16'd0, tmo});
      csr_we <= 1'b0;
      config_phases++;
   endtask

   // one stream: start, producer writes mixed with consumer pulls and ms ticks, a little
   // noise, then optionally end of data and pulls until playback stops or 80 have been sent
   task automatic stream_session(input int n_items);
      int         pick, pulls, half_len, w_write, w_pull, w_tick;
      logic [2:0] op;
      w_write  = $urandom_range(30, 55);
      w_pull   = $urandom_range(20, 40);
      w_tick   = $urandom_range(3, 15);
      half_len = 1 << $urandom_range(0, 3);
      pulls    = 0;
      push_item(OP_START, 8'($urandom), 1'($urandom));
      for (int i = 0; i < n_items; i++) begin
         pick = $urandom_range(0, w_write + w_pull + w_tick + 6);
         if (!sb.active() && $urandom_range(0, 9) == 0) begin
            // restart a stream that ended, so most traffic reaches the active modes
            push_item(OP_START, 8'($urandom), 1'($urandom));
         end else if (pick < w_write) begin
            push_item(OP_WRITE, 8'($urandom), 1'($urandom));
         end else if (pick < w_write + w_pull) begin
            pulls++;
            push_item(OP_PULL, 8'($urandom),
                      (pulls % half_len == 0) ^ ($urandom_range(0, 19) == 0));
         end else if (pick < w_write + w_pull + w_tick) begin
            push_item(OP_TICK, 8'($urandom), 1'($urandom));
         end else if (pick < w_write + w_pull + w_tick + 3) begin
            push_item(OP_END, 8'($urandom), 1'($urandom));
         end else begin
            case ($urandom_range(0, 3))
               0:       op = OP_START;
               1:       op = OP_STOP;
               2:       op = OP_ERROR;
               default: op = OP_UNUSED;
            endcase
            push_item(op, 8'($urandom), 1'($urandom));
         end
         if ($urandom_range(0, 99) == 0) wait_drain();
      end
      if ($urandom_range(0, 1) == 1) push_item(OP_END, 8'($urandom), 1'($urandom));
      for (int i = 0; i < 80; i++) begin
         if (sb.mode != MODE_PLAY && sb.mode != MODE_DRAIN) break;
         push_item(OP_PULL, 8'($urandom), (i % 4 == 3));
      end
   endtask

   // receiver: checks each result transfer, stalls on its own changing pattern
   initial begin
      int   stall_left, pattern_left, stall_pct;
      logic ready_next;
      stall_left   = 0;
      pattern_left = 0;
      stall_pct    = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_status(rsp_tdata, rsp_tuser);
         if (pattern_left == 0) begin
            pattern_left = $urandom_range(50, 400);
            case ($urandom_range(0, 2))
               0:       stall_pct = 0;
               1:       stall_pct = 15;
               default: stall_pct = 50;
            endcase
         end
         pattern_left--;
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
         end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 3);
            ready_next = 1'b0;
         end else begin
            ready_next = 1'b1;
         end
         rsp_tready <= ready_next;
      end
   end

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $error("run did not complete within %0d cycles", CYCLE_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int          random_items, session_len;
      logic [31:0] exp_bytes;
      logic [11:0] prebuf;
      logic [15:0] tmo;
      sb = new();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_START;
      req_tlast  <= 1'b0;
      csr_we     <= 1'b0;
      csr_index  <= CSR_EXPECTED;
      csr_wdata  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // reset registers: every operation while idle, then a start with zero bytes expected
      push_item(OP_PULL, 8'hA5, 1'b1);
      push_item(OP_WRITE, 8'hFF, 1'b0);
      push_item(OP_TICK, 8'h00, 1'b1);
      push_item(OP_END, 8'h5A, 1'b0);
      push_item(OP_UNUSED, 8'hFF, 1'b1);
      push_item(OP_STOP, 8'h00, 1'b0);
      push_item(OP_ERROR, 8'h81, 1'b1);
      push_item(OP_START, 8'h00, 1'b0);
      push_item(OP_WRITE, 8'h00, 1'b0);   // nothing expected: straight to done

      // tiny prebuffer, zero timeout: play, one sample, a short half, then timeout error
      wait_drain();
      program_regs(32'hFFFF_FFFF, 12'd2, 16'd0);
      push_item(OP_START, 8'h00, 1'b0);
      push_item(OP_WRITE, 8'h34, 1'b0);
      push_item(OP_WRITE, 8'h12, 1'b1);
      push_item(OP_PULL, 8'h00, 1'b0);
      push_item(OP_PULL, 8'h00, 1'b1);
      push_item(OP_TICK, 8'h00, 1'b0);
      push_item(OP_STOP, 8'h00, 1'b0);
      push_item(OP_START, 8'hFF, 1'b1);

      // four bytes expected, prebuffer never reached: end of data starts playback,
      // extra byte dropped, an empty half after all data was read finishes the stream
      wait_drain();
      program_regs(32'd4, 12'd4095, 16'd65535);
      push_item(OP_START, 8'h00, 1'b0);
      push_item(OP_WRITE, 8'h00, 1'b0);
      push_item(OP_WRITE, 8'hFF, 1'b0);
      push_item(OP_WRITE, 8'h80, 1'b0);
      push_item(OP_WRITE, 8'h7F, 1'b0);
      push_item(OP_WRITE, 8'hAA, 1'b0);
      push_item(OP_PULL, 8'h00, 1'b0);
      push_item(OP_PULL, 8'h00, 1'b0);
      push_item(OP_PULL, 8'h00, 1'b1);
      push_item(OP_PULL, 8'h00, 1'b1);

      // --- build up the fill back to back while the receiver holds off ---
      wait_drain();
      program_regs(32'hFFFF_FFFF, 12'd4095, 16'd65535);
      fast_mode = 1'b1;
      hold_request = 1'b1;
      push_item(OP_START, 8'($urandom), 1'($urandom));
      for (int i = 0; i < FILL_WRITES; i++)
         push_item(OP_WRITE, 8'($urandom), 1'($urandom));
      fast_mode = 1'b0;
      // buffering only: pulls are ignored while writes keep raising the fill
      for (int i = 0; i < FILL_ROUNDS; i++) begin
         push_item(OP_PULL, 8'($urandom), (i % 8 == 7));
         push_item(OP_WRITE, 8'($urandom), 1'($urandom));
         push_item(OP_WRITE, 8'($urandom), 1'($urandom));
      end
      push_item(OP_STOP, 8'($urandom), 1'($urandom));

      // --- starve playback: short halves counted, quiet ticks pile up ---
      wait_drain();
      program_regs(32'hFFFF_FFFF, 12'd2, 16'd65535);
      fast_mode = 1'b1;
      hold_request = 1'b1;
      push_item(OP_START, 8'($urandom), 1'($urandom));
      push_item(OP_WRITE, 8'($urandom), 1'($urandom));
      push_item(OP_WRITE, 8'($urandom), 1'($urandom));
      push_item(OP_PULL, 8'($urandom), 1'b0);
      for (int i = 0; i < STARVE_ROUNDS; i++) begin
         push_item(OP_TICK, 8'($urandom), 1'($urandom));
         push_item(OP_PULL, 8'($urandom), 1'b1);
      end
      push_item(OP_END, 8'($urandom), 1'($urandom));
      push_item(OP_PULL, 8'($urandom), 1'b1);
      push_item(OP_ERROR, 8'($urandom), 1'($urandom));
      fast_mode = 1'b0;

      // --- random streams, each with its own register setting ---
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         session_len = $urandom_range(40, 200);
         wait_drain();
         case ($urandom_range(0, 5))
            0:       exp_bytes = 32'd0;
            1:       exp_bytes = 32'($urandom_range(1, 3));
            2:       exp_bytes = 32'($urandom_range(4, 400));
            3:       exp_bytes = 32'(2 * $urandom_range(2, 200));
            4:       exp_bytes = 32'hFFFF_FFFF;
            default: exp_bytes = $urandom;
         endcase
         case ($urandom_range(0, 4))
            0:       prebuf = 12'd0;
            1:       prebuf = 12'd1;
            2:       prebuf = 12'($urandom_range(2, 64));
            3:       prebuf = 12'($urandom_range(0, 400));
            default: prebuf = 12'd4095;
         endcase
         case ($urandom_range(0, 3))
            0:       tmo = 16'd0;
            1:       tmo = 16'($urandom_range(1, 30));
            2:       tmo = 16'd5000;
            default: tmo = 16'd65535;
         endcase
         program_regs(exp_bytes, prebuf, tmo);
         fast_mode = ($urandom_range(0, 3) == 0);
         stream_session(session_len);
         random_items += session_len;
      end
      fast_mode = 1'b0;

      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d request transfers, %0d results checked, %0d register settings",
               sb.transfers_in, sb.statuses_seen, config_phases);
      $display("peak fill %0d bytes, peak underrun count %0d, modes reached %b",
               sb.peak_fill, sb.peak_underruns, sb.modes_reached);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
